[hdl/kde_pkg.sv]
package kde_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int MAX_CHANNELS = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   typedef logic [3:0] chan_type;

   typedef enum logic [2:0] {
      EV_RELEASE      = 3'd0,
      EV_PRESS        = 3'd1,
      EV_LONG_PRESS   = 3'd2,
      EV_LONG_RELEASE = 3'd3,
      EV_REPEAT       = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      MODE_PLAIN     = 2'd0,
      MODE_HOLD      = 2'd1,
      MODE_REPEAT    = 2'd2,
      MODE_PLAIN_ALT = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_COUNT = 3'd0,
      CSR_HOLD_COUNT     = 3'd1,
      CSR_REPEAT_COUNT   = 3'd2,
      CSR_INVERT_MASK    = 3'd3,
      CSR_ENABLE_MASK    = 3'd4,
      CSR_KEY_MODES      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_PROC,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [7:0]  debounce_count;
      logic [15:0] hold_count;
      logic [15:0] repeat_count;
      logic [15:0] invert_mask;
      logic [15:0] enable_mask;
      logic [31:0] key_modes;
   } cfg_type;

   // per-channel state word held in the state memory
   typedef struct packed {
      logic        raw_prev;
      logic [7:0]  deb_cnt;
      logic        stable;
      logic        key_prev;
      logic [15:0] hold_cnt;
      logic [15:0] rep_cnt;
   } entry_type;

   typedef struct packed {
      logic [15:0] raw_pins;
      logic        run_debounce;
      logic        run_keys;
   } tick_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      chan_type addr;
   } mem_ctl_type;

endpackage

[hdl/kde_req_if.sv]
interface kde_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_pins;
   logic        run_debounce;
   logic        run_keys;

   modport source (output valid, raw_pins, run_debounce, run_keys, input ready);
   modport sink   (input valid, raw_pins, run_debounce, run_keys, output ready);
endinterface

[hdl/kde_rsp_if.sv]
interface kde_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] channel;
   logic [2:0] event_code;
   logic       last_event;

   modport source (output valid, channel, event_code, last_event, input ready);
   modport sink   (input valid, channel, event_code, last_event, output ready);
endinterface

[hdl/kde_state_mem.sv]
module kde_state_mem #(
   parameter int CHANNELS = kde_pkg::CHANNELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  kde_pkg::mem_ctl_type mem_ctl,
   input  kde_pkg::entry_type  wr_entry,
   output kde_pkg::entry_type  rd_entry
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   kde_pkg::entry_type mem_ff [CHANNELS];
   logic               vld_ff [CHANNELS];
   kde_pkg::entry_type rd_data_ff;
   logic               rd_vld_ff;
   logic [AW-1:0]      addr;

   assign addr = mem_ctl.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[addr] <= wr_entry;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   // entries never written read as the reset value, all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_ctl.wr_en) begin
            vld_ff[addr] <= 1'b1;
         end
         if (mem_ctl.rd_en) begin
            rd_vld_ff <= vld_ff[addr];
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

[hdl/kde_update.sv]
module kde_update (
   input  kde_pkg::cfg_type   cfg,
   input  kde_pkg::tick_type  tick,
   input  kde_pkg::chan_type  chan,
   input  kde_pkg::entry_type cur,
   output kde_pkg::entry_type nxt,
   output logic               ev_valid,
   output kde_pkg::event_type ev_code
);

   logic              level;
   kde_pkg::mode_type mode;
   logic [15:0]       hold_inc;

   assign level    = tick.raw_pins[chan] ^ cfg.invert_mask[chan];
   assign mode     = kde_pkg::mode_type'(cfg.key_modes[{chan, 1'b0} +: 2]);
   assign hold_inc = cur.hold_cnt + 16'd1;

   always_comb begin
      nxt      = cur;
      ev_valid = 1'b0;
      ev_code  = kde_pkg::EV_RELEASE;

      // debounce first; the key pass sees the updated stable level
      if (tick.run_debounce) begin
         nxt.raw_prev = level;
         if (level != cur.raw_prev) begin
            nxt.deb_cnt = '0;
         end else if (cur.deb_cnt != cfg.debounce_count) begin
            nxt.deb_cnt = cur.deb_cnt + 8'd1;
         end else begin
            nxt.stable = level;
         end
      end

      if (tick.run_keys && cfg.enable_mask[chan]) begin
         nxt.key_prev = nxt.stable;
         if (nxt.stable != cur.key_prev) begin
            ev_valid = 1'b1;
            if (mode == kde_pkg::MODE_HOLD && !nxt.stable &&
                cur.hold_cnt == cfg.hold_count) begin
               ev_code = kde_pkg::EV_LONG_RELEASE;
            end else if (nxt.stable) begin
               ev_code = kde_pkg::EV_PRESS;
            end else begin
               ev_code = kde_pkg::EV_RELEASE;
            end
            nxt.hold_cnt = '0;
            nxt.rep_cnt  = '0;
         end else if (mode != kde_pkg::MODE_PLAIN && nxt.stable) begin
            if (cur.hold_cnt != cfg.hold_count) begin
               nxt.hold_cnt = hold_inc;
               if (hold_inc == cfg.hold_count && mode == kde_pkg::MODE_HOLD) begin
                  ev_valid = 1'b1;
                  ev_code  = kde_pkg::EV_LONG_PRESS;
               end
            end else if (mode == kde_pkg::MODE_REPEAT) begin
               if (cur.rep_cnt != cfg.repeat_count) begin
                  nxt.rep_cnt = cur.rep_cnt + 16'd1;
               end else begin
                  nxt.rep_cnt = '0;
                  ev_valid    = 1'b1;
                  ev_code     = kde_pkg::EV_REPEAT;
               end
            end
         end
      end
   end

endmodule

[hdl/kde_seq.sv]
module kde_seq #(
   parameter int CHANNELS = kde_pkg::CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   kde_req_if.sink              req_chan,
   kde_rsp_if.source            rsp_chan,
   output kde_pkg::mem_ctl_type mem_ctl,
   output kde_pkg::tick_type    tick,
   output kde_pkg::chan_type    chan,
   input  logic                 ev_valid,
   input  kde_pkg::event_type   ev_code
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   kde_pkg::state_type state_ff, state_in;
   kde_pkg::tick_type  tick_ff, tick_in;
   logic [AW-1:0]      ch_ff, ch_in;

   logic               pend_valid_ff, pend_valid_in;
   kde_pkg::chan_type  pend_chan_ff, pend_chan_in;
   kde_pkg::event_type pend_code_ff, pend_code_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kde_pkg::chan_type  rsp_chan_ff, rsp_chan_in;
   kde_pkg::event_type rsp_code_ff, rsp_code_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               stall;
   logic               last_ch;
   logic               rsp_load;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_ch  = (ch_ff == AW'(CHANNELS - 1));
   assign stall    = (state_ff == kde_pkg::S_PROC) && ev_valid && pend_valid_ff && !out_free;

   assign chan = kde_pkg::chan_type'(ch_ff);
   assign tick = tick_ff;

   assign mem_ctl.rd_en = (state_ff == kde_pkg::S_READ);
   assign mem_ctl.wr_en = (state_ff == kde_pkg::S_PROC) && !stall;
   assign mem_ctl.addr  = chan;

   assign req_chan.ready      = (state_ff == kde_pkg::S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.channel    = rsp_chan_ff;
   assign rsp_chan.event_code = rsp_code_ff;
   assign rsp_chan.last_event = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kde_pkg::S_IDLE: begin
            if (req_chan.valid) state_in = kde_pkg::S_READ;
         end
         kde_pkg::S_READ: begin
            state_in = kde_pkg::S_PROC;
         end
         kde_pkg::S_PROC: begin
            if (!stall) state_in = last_ch ? kde_pkg::S_FLUSH : kde_pkg::S_READ;
         end
         kde_pkg::S_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = kde_pkg::S_IDLE;
         end
         default: state_in = kde_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      tick_in       = tick_ff;
      ch_in         = ch_ff;
      pend_valid_in = pend_valid_ff;
      pend_chan_in  = pend_chan_ff;
      pend_code_in  = pend_code_ff;
      rsp_load      = 1'b0;
      rsp_chan_in   = rsp_chan_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         kde_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               tick_in.raw_pins     = req_chan.raw_pins;
               tick_in.run_debounce = req_chan.run_debounce;
               tick_in.run_keys     = req_chan.run_keys;
               ch_in                = '0;
            end
         end
         kde_pkg::S_READ: begin
         end
         kde_pkg::S_PROC: begin
            if (!stall) begin
               if (!last_ch) ch_in = ch_ff + AW'(1);
               // a new event pushes the held one out; it cannot be the last
               if (ev_valid) begin
                  if (pend_valid_ff) begin
                     rsp_load    = 1'b1;
                     rsp_chan_in = pend_chan_ff;
                     rsp_code_in = pend_code_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_chan_in  = chan;
                  pend_code_in  = ev_code;
               end
            end
         end
         kde_pkg::S_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_load      = 1'b1;
               rsp_chan_in   = pend_chan_ff;
               rsp_code_in   = pend_code_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kde_pkg::S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ch_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ch_ff         <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff      <= tick_in;
      pend_chan_ff <= pend_chan_in;
      pend_code_ff <= pend_code_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("state memory read and write in the same cycle");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !pend_valid_ff)
      else $error("new transaction accepted while an event is still held");

   a_stall_holds_proc: assert property (@(posedge clock) disable iff (reset)
      stall |=> (state_ff == kde_pkg::S_PROC) && $stable(ch_ff))
      else $error("channel advanced while its event could not be stored");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == kde_pkg::S_FLUSH) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final event of a tick not marked last");

endmodule

[hdl/key_debounce_event_generator.sv]
// Key debounce and event generator. Each transaction on req_chan is one tick: raw
// pin levels for every channel plus flags that select the debounce pass, the key
// pass, or both. The block walks the channels in order through a single state
// memory, with a read state and then a modify/write state for each channel; the
// modify/write state waits while rsp_chan back-pressure keeps a new event from
// being stored. Events come out in increasing channel order, at most one per
// channel, and last_event marks the final event of a tick; a tick with no events
// yields no transaction. Configuration registers are written through the csr_
// port and must only change while no tick is in progress.
module key_debounce_event_generator #(
   parameter int CHANNELS = kde_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   kde_req_if.sink                         req_chan,
   kde_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [kde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kde_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   kde_pkg::cfg_type     cfg_ff, cfg_in;
   kde_pkg::mem_ctl_type mem_ctl;
   kde_pkg::tick_type    tick;
   kde_pkg::chan_type    chan;
   kde_pkg::entry_type   rd_entry;
   kde_pkg::entry_type   wr_entry;
   logic                 ev_valid;
   kde_pkg::event_type   ev_code;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            kde_pkg::CSR_DEBOUNCE_COUNT: cfg_in.debounce_count = csr_wdata[7:0];
            kde_pkg::CSR_HOLD_COUNT:     cfg_in.hold_count     = csr_wdata[15:0];
            kde_pkg::CSR_REPEAT_COUNT:   cfg_in.repeat_count   = csr_wdata[15:0];
            kde_pkg::CSR_INVERT_MASK:    cfg_in.invert_mask    = csr_wdata[15:0];
            kde_pkg::CSR_ENABLE_MASK:    cfg_in.enable_mask    = csr_wdata[15:0];
            kde_pkg::CSR_KEY_MODES:      cfg_in.key_modes      = csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count <= 8'd3;
         cfg_ff.hold_count     <= 16'd100;
         cfg_ff.repeat_count   <= 16'd10;
         cfg_ff.invert_mask    <= '0;
         cfg_ff.enable_mask    <= '0;
         cfg_ff.key_modes      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kde_seq #(
      .CHANNELS (CHANNELS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_ctl  (mem_ctl),
      .tick     (tick),
      .chan     (chan),
      .ev_valid (ev_valid),
      .ev_code  (ev_code)
   );

   kde_state_mem #(
      .CHANNELS (CHANNELS)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_ctl  (mem_ctl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   kde_update u_update (
      .cfg      (cfg_ff),
      .tick     (tick),
      .chan     (chan),
      .cur      (rd_entry),
      .nxt      (wr_entry),
      .ev_valid (ev_valid),
      .ev_code  (ev_code)
   );

endmodule
